/* sv/rsbk_pkg.sv */
// ============================================================================
// rsbk_pkg - shared types and constants of the record sorter
// Record layout, beat widths, controller states and the control/status
// bundles exchanged between the controller and the cell chain.
// ============================================================================
package rsbk_pkg;

    localparam int KEY_W    = 20;
    localparam int TAG_W    = 8;
    localparam int RANK_W   = 5;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;
    localparam int S_PAD_W  = S_DATA_W - KEY_W - TAG_W;
    localparam int M_PAD_W  = M_DATA_W - RANK_W - KEY_W - TAG_W;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

    typedef enum logic {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } t_state;

    // controller to every cell
    typedef struct packed {
        logic load;   // insert the broadcast record
        logic pop;    // shift the chain one place toward cell 0
    } t_cell_ctrl;

    // chain to controller
    typedef struct packed {
        logic full;   // last cell holds a record
        logic more;   // cell 1 holds a record: head is not the final one
    } t_chain_stat;

endpackage

/* sv/rsbk_cell.sv */
// ============================================================================
// rsbk_cell - one slot of the insertion chain
// Holds one record and a valid bit. On load it keeps, takes the new record
// or takes its left neighbor's record; on pop it takes its right neighbor's.
// ============================================================================
module rsbk_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rsbk_pkg::t_cell_ctrl i_ctrl,
    input  rsbk_pkg::t_rec       i_new,
    input  logic                 i_prev_ins,
    input  logic                 i_prev_valid,
    input  rsbk_pkg::t_rec       i_prev_rec,
    input  logic                 i_next_valid,
    input  rsbk_pkg::t_rec       i_next_rec,
    output logic                 o_ins,
    output logic                 o_valid,
    output rsbk_pkg::t_rec       o_rec
);

    logic           r_valid;
    logic           n_valid;
    rsbk_pkg::t_rec r_rec;
    rsbk_pkg::t_rec n_rec;

    // new record belongs at or before this slot; strict compare keeps ties stable
    assign o_ins   = !r_valid || (r_rec.key > i_new.key);
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    // select next slot content
    always_comb begin
        n_valid = r_valid;
        n_rec   = r_rec;
        if (i_ctrl.pop) begin
            n_valid = i_next_valid;
            n_rec   = i_next_rec;
        end else if (i_ctrl.load && o_ins) begin
            if (i_prev_ins) begin
                n_valid = i_prev_valid;
                n_rec   = i_prev_rec;
            end else begin
                n_valid = 1'b1;
                n_rec   = i_new;
            end
        end
    end

    // valid bit under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload holds no reset
    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

/* sv/rsbk_ctrl.sv */
// ============================================================================
// rsbk_ctrl - load/drain sequencer of the record sorter
// Loads records until the marked one, then drains the chain head by head,
// keeping the rank counter and the dropped flag of the current set.
// ============================================================================
module rsbk_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_last,
    input  logic                             i_out_ready,
    input  rsbk_pkg::t_chain_stat            i_stat,
    output logic                             o_in_ready,
    output logic                             o_out_valid,
    output logic                             o_out_last,
    output logic [rsbk_pkg::RANK_W-1:0]      o_rank,
    output logic                             o_overflow,
    output rsbk_pkg::t_cell_ctrl             o_ctrl
);

    rsbk_pkg::t_state            r_state;
    rsbk_pkg::t_state            n_state;
    logic [rsbk_pkg::RANK_W-1:0] r_rank;
    logic                        r_dropped;
    logic                        in_fire;
    logic                        out_fire;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsbk_pkg::ST_LOAD: begin
                if (in_fire && i_in_last) begin
                    n_state = rsbk_pkg::ST_DRAIN;
                end
            end
            rsbk_pkg::ST_DRAIN: begin
                if (out_fire && !i_stat.more) begin
                    n_state = rsbk_pkg::ST_LOAD;
                end
            end
            default: n_state = rsbk_pkg::ST_LOAD;
        endcase
    end

    // outputs from state
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            rsbk_pkg::ST_LOAD:  o_in_ready  = 1'b1;
            rsbk_pkg::ST_DRAIN: o_out_valid = 1'b1;
            default: begin
                o_in_ready  = 1'b0;
                o_out_valid = 1'b0;
            end
        endcase
    end

    assign o_out_last = !i_stat.more;
    assign o_rank     = r_rank;
    assign o_overflow = r_dropped;
    assign o_ctrl     = '{load: in_fire && !i_stat.full, pop: out_fire};

    // state, rank and dropped flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rsbk_pkg::ST_LOAD;
            r_rank    <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire && i_stat.full) begin
                r_dropped <= 1'b1;
            end
            if (out_fire) begin
                if (!i_stat.more) begin
                    r_rank    <= '0;
                    r_dropped <= 1'b0;
                end else begin
                    r_rank <= r_rank + 1'b1;
                end
            end
        end
    end

endmodule

/* sv/record_sort_by_key.sv */
// ============================================================================
// record_sort_by_key - stable insertion sorter for sets of keyed records
// Top level: a chain of CAPACITY cells kept in ascending key order plus a
// load/drain controller.
// ============================================================================
// Usage
//   Slave side carries one record per beat: key and tag in tdata, tlast marks
//   the final record of a set. Each accepted record is placed in the chain
//   in the same cycle, so a set loads at one record per cycle.
//   In the cycle after the tlast beat the master side starts to present the
//   held records in ascending key order, one per cycle while tready is high;
//   equal keys come out in arrival order. The slave side is held off
//   (tready low) for the whole drain, set by the single shared cell chain.
//   Records arriving while all CAPACITY cells are full are dropped and the
//   set's results carry tuser (overflow) high. Rank wraps modulo 32.
//   A master-side stall freezes the chain and holds the presented beat.
//   Reset clears every cell's valid bit and returns to loading; no sweep.
// ============================================================================
module record_sort_by_key #(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // lap_key[19:0], car_tag[27:20], zero pad
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // rank[4:0], key_out[24:5], tag_out[32:25], pad
    output logic        m_axis_tuser,   // overflow
    output logic        m_axis_tlast    // last_out
);

    rsbk_pkg::t_rec              w_new;
    rsbk_pkg::t_rec              w_rec   [CAPACITY];
    logic                        w_valid [CAPACITY];
    logic                        w_ins   [CAPACITY];
    rsbk_pkg::t_cell_ctrl        w_ctrl;
    rsbk_pkg::t_chain_stat       w_stat;
    logic [rsbk_pkg::RANK_W-1:0] w_rank;

    // unpack the incoming beat
    assign w_new.key = s_axis_tdata[rsbk_pkg::KEY_W-1:0];
    assign w_new.tag = s_axis_tdata[rsbk_pkg::KEY_W +: rsbk_pkg::TAG_W];

    assign w_stat.full = w_valid[CAPACITY-1];
    assign w_stat.more = w_valid[1];

    rsbk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_last  (m_axis_tlast),
        .o_rank      (w_rank),
        .o_overflow  (m_axis_tuser),
        .o_ctrl      (w_ctrl)
    );

    // build the cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic           prev_ins;
        logic           prev_valid;
        rsbk_pkg::t_rec prev_rec;
        logic           next_valid;
        rsbk_pkg::t_rec next_rec;

        if (g == 0) begin : g_head
            assign prev_ins   = 1'b0;
            assign prev_valid = 1'b1;
            assign prev_rec   = w_new;
        end else begin : g_body
            assign prev_ins   = w_ins[g-1];
            assign prev_valid = w_valid[g-1];
            assign prev_rec   = w_rec[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_rec   = w_new;
        end else begin : g_inner
            assign next_valid = w_valid[g+1];
            assign next_rec   = w_rec[g+1];
        end

        rsbk_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_new        (w_new),
            .i_prev_ins   (prev_ins),
            .i_prev_valid (prev_valid),
            .i_prev_rec   (prev_rec),
            .i_next_valid (next_valid),
            .i_next_rec   (next_rec),
            .o_ins        (w_ins[g]),
            .o_valid      (w_valid[g]),
            .o_rec        (w_rec[g])
        );
    end

    // pack the head of the chain
    assign m_axis_tdata = {{rsbk_pkg::M_PAD_W{1'b0}}, w_rec[0].tag, w_rec[0].key, w_rank};

endmodule

/* sv/rsbk_checker.sv */
// ============================================================================
// rsbk_checker - port-level checks of the record sorter
// Watches both stream sides and the drain sequence seen on the ports.
// ============================================================================
module rsbk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // never load and drain at once
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("load and drain active together");

    // a closing record starts the drain
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast)
        |=> (m_axis_tvalid && m_axis_tdata[4:0] == 5'd0))
        else $error("drain did not start at rank zero");

    // ranks advance by one within a run
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
        |=> (m_axis_tvalid && m_axis_tdata[4:0] == $past(m_axis_tdata[4:0]) + 5'd1))
        else $error("rank did not advance");

    // the final result reopens the input
    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("input not reopened after final result");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind record_sort_by_key rsbk_checker u_rsbk_checker (.*);
